/* hdl/adcvm_pkg.sv */
package adcvm_pkg;

  // Millivolt value width and limits
  localparam int MV_W = 14;
  localparam logic [MV_W-1:0] MV_MAX = 14'd9999;
  localparam logic [MV_W-1:0] FS_RESET = 14'd5000;

  // Divide by ten for values below 2^16: q = (v * 52429) >> 19
  localparam int DIV10_MUL_W = 16;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;
  localparam int DIV10_SHIFT = 19;
  localparam int QUO_W = 10;

  // Digit positions, ones first
  localparam int DIGIT_IDX_W = 2;
  localparam logic [DIGIT_IDX_W-1:0] DIGIT_ONES = 2'd0;
  localparam logic [DIGIT_IDX_W-1:0] DIGIT_TENS = 2'd1;
  localparam logic [DIGIT_IDX_W-1:0] DIGIT_HUNDREDS = 2'd2;
  localparam logic [DIGIT_IDX_W-1:0] DIGIT_THOUSANDS = 2'd3;

  // Active-low digit selects
  localparam logic [3:0] SEL_ONES = 4'h7;
  localparam logic [3:0] SEL_TENS = 4'hb;
  localparam logic [3:0] SEL_HUNDREDS = 4'hd;
  localparam logic [3:0] SEL_THOUSANDS = 4'he;

  localparam logic [7:0] SEG_DP = 8'h80;

  // Common-cathode segment pattern, bits 0-6 = a-g
  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0: seg = 8'h3f;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5b;
      4'd3: seg = 8'h4f;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6d;
      4'd6: seg = 8'h7d;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7f;
      4'd9: seg = 8'h6f;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [3:0] sel_of(input logic [DIGIT_IDX_W-1:0] idx);
    logic [3:0] sel;
    unique case (idx)
      DIGIT_ONES: sel = SEL_ONES;
      DIGIT_TENS: sel = SEL_TENS;
      DIGIT_HUNDREDS: sel = SEL_HUNDREDS;
      DIGIT_THOUSANDS: sel = SEL_THOUSANDS;
      default: sel = SEL_ONES;
    endcase
    return sel;
  endfunction

endpackage

/* hdl/adcvm_front.sv */
module adcvm_front #(
  parameter int CODE_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [CODE_BITS-1:0]            adc_code,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [adcvm_pkg::MV_W-1:0]      cfg_data,
  input  logic                            q_full,
  output logic                            q_push,
  output logic [adcvm_pkg::MV_W-1:0]      q_data
);

  localparam int PW = CODE_BITS + adcvm_pkg::MV_W;

  logic [adcvm_pkg::MV_W-1:0] full_scale;
  logic [PW-1:0]              prod;
  logic                       prod_valid;
  logic                       accept;
  logic [adcvm_pkg::MV_W-1:0] mv_raw;

  // Full-scale register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= adcvm_pkg::FS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      full_scale <= cfg_data;
    end
  end

  // Scale stage: code * full scale
  assign q_push = prod_valid && !q_full;
  assign full   = prod_valid && q_full;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (!prod_valid || q_push) begin
      prod_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod <= PW'(adc_code) * PW'(full_scale);
    end
  end

  // Drop the fraction and saturate
  assign mv_raw = prod[PW-1:CODE_BITS];
  assign q_data = (mv_raw > adcvm_pkg::MV_MAX) ? adcvm_pkg::MV_MAX : mv_raw;

endmodule

/* hdl/adcvm_fifo.sv */
module adcvm_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  output logic                       q_full,
  input  logic [adcvm_pkg::MV_W-1:0] wr_data,
  input  logic                       rd,
  output logic                       q_empty,
  output logic [adcvm_pkg::MV_W-1:0] rd_data
);

  // Two-entry queue between front and back
  logic [adcvm_pkg::MV_W-1:0] mem [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (wr && !rd) begin
        count <= count + 2'd1;
      end else if (rd && !wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* hdl/adcvm_back.sv */
module adcvm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [adcvm_pkg::MV_W-1:0] q_data,
  output logic                       empty,
  input  logic                       pop,
  output logic [3:0]                 digit_select_n,
  output logic [7:0]                 segments,
  output logic                       last
);

  localparam int MW = adcvm_pkg::MV_W + adcvm_pkg::DIV10_MUL_W;

  logic [adcvm_pkg::MV_W-1:0]        cur;
  logic [adcvm_pkg::DIGIT_IDX_W-1:0] idx;
  logic                              busy;
  logic                              out_valid;
  logic                              out_load;
  logic                              step;
  logic                              final_digit;
  logic                              load;
  logic [MW-1:0]                     prod10;
  logic [adcvm_pkg::QUO_W-1:0]       quo;
  logic [adcvm_pkg::MV_W-1:0]        times10;
  logic [3:0]                        rem;

  // Divide by ten: quotient and remainder digit
  assign prod10  = MW'(cur) * MW'(adcvm_pkg::DIV10_MUL);
  assign quo     = prod10[adcvm_pkg::DIV10_SHIFT +: adcvm_pkg::QUO_W];
  assign times10 = adcvm_pkg::MV_W'({quo, 3'b000}) + adcvm_pkg::MV_W'({quo, 1'b0});
  assign rem     = 4'(cur - times10);

  // Handshake between digit sequencer and output register
  assign out_load    = !out_valid || pop;
  assign step        = busy && out_load;
  assign final_digit = (idx == adcvm_pkg::DIGIT_THOUSANDS);
  assign load        = !q_empty && (!busy || (step && final_digit));
  assign q_pop       = load;
  assign empty       = !out_valid;

  // Digit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= adcvm_pkg::DIGIT_ONES;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= adcvm_pkg::DIGIT_ONES;
    end else if (step) begin
      if (final_digit) begin
        busy <= 1'b0;
      end
      idx <= idx + adcvm_pkg::DIGIT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end else if (step) begin
      cur <= adcvm_pkg::MV_W'(quo);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      digit_select_n <= adcvm_pkg::sel_of(idx);
      segments       <= adcvm_pkg::seg_of(rem) | (final_digit ? adcvm_pkg::SEG_DP : 8'h00);
      last           <= final_digit;
    end
  end

endmodule

/* hdl/adc_code_to_seven_segment_voltmeter.sv */
// A code is scaled in the front stage, then a 2-entry queue decouples front and back.
// The back end puts the digits on the result ports ones first, thousands last, emitting
// one digit per cycle while results are taken, through a single divide-by-ten multiplier.
// New codes are taken while earlier ones are being split, until queue and scale stage are full.
// Reset (rst, synchronous, active high) empties all stages and sets full scale to 5000 mV.
module adc_code_to_seven_segment_voltmeter #(
  parameter int CODE_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [CODE_BITS-1:0]       adc_code,
  output logic                       empty,
  input  logic                       pop,
  output logic [3:0]                 digit_select_n,
  output logic [7:0]                 segments,
  output logic                       last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [adcvm_pkg::MV_W-1:0] cfg_data
);

  logic                       q_full;
  logic                       q_empty;
  logic                       q_push;
  logic                       q_pop;
  logic [adcvm_pkg::MV_W-1:0] q_wr_data;
  logic [adcvm_pkg::MV_W-1:0] q_rd_data;

  adcvm_front #(
    .CODE_BITS(CODE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .adc_code  (adc_code),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  adcvm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .q_full  (q_full),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .q_empty (q_empty),
    .rd_data (q_rd_data)
  );

  adcvm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_data         (q_rd_data),
    .empty          (empty),
    .pop            (pop),
    .digit_select_n (digit_select_n),
    .segments       (segments),
    .last           (last)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int CODE_W = 12;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RAND_PHASES = 6;
  localparam int CODES_PER_PHASE = 60;
  localparam logic [adcvm_pkg::MV_W-1:0] SCALE_TOP = {adcvm_pkg::MV_W{1'b1}};

  typedef enum bit {OP_CODE, OP_SCALE} op_kind_t;

  typedef struct {
    op_kind_t kind;
    logic [adcvm_pkg::MV_W-1:0] value;
    int unsigned gap;
  } op_t;

  typedef struct {
    logic [3:0] sel;
    logic [7:0] seg;
    logic last;
  } digit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [CODE_W-1:0] adc_code = '0;
  logic empty;
  logic pop = 1'b0;
  logic [3:0] digit_select_n;
  logic [7:0] segments;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [adcvm_pkg::MV_W-1:0] cfg_data = '0;

  adc_code_to_seven_segment_voltmeter #(
    .CODE_BITS(CODE_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .adc_code(adc_code),
    .empty(empty),
    .pop(pop),
    .digit_select_n(digit_select_n),
    .segments(segments),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Segment patterns and selects, ones position first
  logic [7:0] seg_pat [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                               8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};
  logic [3:0] sel_by_pos [4] = '{adcvm_pkg::SEL_ONES, adcvm_pkg::SEL_TENS,
                                 adcvm_pkg::SEL_HUNDREDS, adcvm_pkg::SEL_THOUSANDS};

  op_t pending[$];
  digit_t digit_q[$];
  digit_t want_digit;
  logic [adcvm_pkg::MV_W-1:0] scale_mv = adcvm_pkg::FS_RESET;

  bit push_busy = 1'b0;
  bit cfg_busy = 1'b0;
  int quiet = 0;
  int unsigned gap_max = 15;
  int unsigned stall_max = 15;
  int unsigned stall_left = 0;
  int cycles = 0;
  int errors = 0;
  int codes_sent = 0;
  int scales_set = 0;
  int digits_seen = 0;
  int saturated = 0;
  int zero_scale = 0;

  // Expected digits for one code at the current full scale
  task automatic queue_digits(input logic [CODE_W-1:0] code);
    int unsigned mv;
    int unsigned rest;
    digit_t d;
    mv = (int'(code) * int'(scale_mv)) >> CODE_W;
    if (mv > int'(adcvm_pkg::MV_MAX)) begin
      mv = int'(adcvm_pkg::MV_MAX);
      saturated++;
    end
    if (scale_mv == 0) zero_scale++;
    rest = mv;
    for (int pos = 0; pos < 4; pos++) begin
      d.sel = sel_by_pos[pos];
      d.seg = seg_pat[rest % 10];
      d.last = (pos == 3);
      if (pos == 3) d.seg = d.seg | adcvm_pkg::SEG_DP;
      digit_q.push_back(d);
      rest = rest / 10;
    end
  endtask

  task automatic add_code(input logic [CODE_W-1:0] code);
    op_t op;
    op.kind = OP_CODE;
    op.value = adcvm_pkg::MV_W'(code);
    op.gap = $urandom_range(0, gap_max);
    pending.push_back(op);
  endtask

  task automatic add_scale(input logic [adcvm_pkg::MV_W-1:0] value);
    op_t op;
    op.kind = OP_SCALE;
    op.value = value;
    op.gap = 0;
    pending.push_back(op);
  endtask

  // Driver: codes and scale writes from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      push_busy = 1'b0;
      cfg_busy = 1'b0;
      quiet = 0;
      push <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (push && !full) begin
        queue_digits(adc_code);
        push_busy = 1'b0;
        codes_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        scale_mv = cfg_data;
        cfg_busy = 1'b0;
        scales_set++;
      end
      // scale writes only once the block has drained
      if (push_busy || digit_q.size() != 0) quiet = 0;
      else if (quiet < DRAIN_CYCLES) quiet++;
      if (!push_busy && !cfg_busy && pending.size() != 0) begin
        if (pending[0].kind == OP_SCALE) begin
          if (quiet >= DRAIN_CYCLES) begin
            cfg_data <= pending[0].value;
            cfg_busy = 1'b1;
            void'(pending.pop_front());
          end
        end else if (pending[0].gap != 0) begin
          pending[0].gap = pending[0].gap - 1;
        end else begin
          adc_code <= pending[0].value[CODE_W-1:0];
          push_busy = 1'b1;
          void'(pending.pop_front());
        end
      end
      push <= push_busy;
      cfg_valid <= cfg_busy;
    end
  end

  // Monitor: compare each digit with the oldest expected one
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (digit_q.size() == 0) begin
          $error("unexpected digit: digit_select_n %0h segments %0h last %0b",
                 digit_select_n, segments, last);
          errors++;
        end else begin
          want_digit = digit_q.pop_front();
          if (digit_select_n !== want_digit.sel) begin
            $error("digit_select_n: expected %0h, actual %0h", want_digit.sel, digit_select_n);
            errors++;
          end
          if (segments !== want_digit.seg) begin
            $error("segments: expected %0h, actual %0h", want_digit.seg, segments);
            errors++;
          end
          if (last !== want_digit.last) begin
            $error("last: expected %0b, actual %0b", want_digit.last, last);
            errors++;
          end
        end
        digits_seen++;
        // switch between stalling and free-running stretches
        if (digits_seen % 100 == 0) stall_max = ($urandom_range(0, 1) != 0) ? 15 : 0;
        stall_left = $urandom_range(0, stall_max);
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits still expected", cycles, digit_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    logic [adcvm_pkg::MV_W-1:0] scale;

    // Directed: reset scale, both code extremes and single bits
    add_code(12'd0);
    add_code(12'hfff);
    add_code(12'd1);
    add_code(12'h800);
    add_code(12'haaa);
    add_code(12'h555);
    // unit scale: millivolts equal the code, so every digit shows up
    add_scale(14'd4096);
    add_code(12'd1234);
    add_code(12'd3456);
    add_code(12'd789);
    add_code(12'd4095);
    add_code(12'd9);
    // scale beyond 9999, millivolts of large codes saturate
    add_scale(SCALE_TOP);
    add_code(12'hfff);
    add_code(12'd2500);
    add_code(12'd2000);
    // zero scale shows all zeros
    add_scale(14'd0);
    add_code(12'hfff);
    add_code(12'd1234);
    add_scale(14'd1);
    add_code(12'hfff);
    add_code(12'd0);
    add_scale(adcvm_pkg::MV_MAX);
    add_code(12'hfff);
    add_code(12'd2048);

    // Random phases, each at its own full scale
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick = $urandom_range(0, 6);
      unique case (pick)
        0: scale = 14'd1;
        1: scale = adcvm_pkg::MV_MAX;
        2: scale = adcvm_pkg::FS_RESET;
        3: scale = 14'd0;
        4: scale = SCALE_TOP;
        5: scale = adcvm_pkg::MV_W'($urandom_range(1, 9999));
        default: scale = adcvm_pkg::MV_W'($urandom_range(0, 16383));
      endcase
      add_scale(scale);
      gap_max = (ph % 2 == 0) ? 15 : 0;
      for (int i = 0; i < CODES_PER_PHASE; i++) begin
        pick = $urandom_range(0, 9);
        unique case (pick)
          0: add_code(12'd0);
          1: add_code(12'hfff);
          2: add_code(CODE_W'(1) << $urandom_range(0, CODE_W - 1));
          default: add_code(CODE_W'($urandom_range(0, 4095)));
        endcase
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || push_busy || cfg_busy || digit_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d codes over %0d full-scale settings, %0d digits checked",
             codes_sent, scales_set, digits_seen);
    $display("%0d codes saturated at 9999 mV, %0d codes at zero scale", saturated, zero_scale);
    if (errors == 0 && digit_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* adc_code_to_seven_segment_voltmeter.f */
hdl/adcvm_pkg.sv
hdl/adcvm_front.sv
hdl/adcvm_fifo.sv
hdl/adcvm_back.sv
hdl/adc_code_to_seven_segment_voltmeter.sv
sim/testbench.sv
